// ----- rtl/spq_pkg.sv -----
// Package for the sorted priority queue: entry and command types,
// operation and status codes, and the default capacity.
// No dependencies.
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int DATA_W = 32;
  localparam int OCC_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic vld;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } cmd_t;

endpackage

// ----- rtl/spq_req_if.sv -----
// Request channel of the sorted priority queue: valid/ready and the request fields.
// Depends on spq_pkg.
interface spq_req_if
  import spq_pkg::*;
;
  logic valid;
  logic ready;
  logic operation;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] priority_req;

  modport source (output valid, operation, value, priority_req, input ready);
  modport sink (input valid, operation, value, priority_req, output ready);
endinterface

// ----- rtl/spq_rsp_if.sv -----
// Result channel of the sorted priority queue: valid/ready and the result fields.
// Depends on spq_pkg.
interface spq_rsp_if
  import spq_pkg::*;
;
  logic valid;
  logic ready;
  logic front_valid;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] front_priority;
  logic [OCC_W-1:0] occupancy;
  logic [1:0] status;

  modport source (output valid, front_valid, front_value, front_priority, occupancy, status,
                  input ready);
  modport sink (input valid, front_valid, front_value, front_priority, occupancy, status,
                output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry, compares it with the incoming
// priority and takes its own, the new, the left or the right entry each cycle.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   cmd,
  input  entry_t left,
  input  logic   left_after,
  input  entry_t right,
  output entry_t cur,
  output logic   after,
  output entry_t nxt
);

  entry_t slot;

  assign cur = slot;
  assign after = slot.vld && (slot.prio >= cmd.prio);

  always_comb begin
    nxt = slot;
    if (cmd.remove) begin
      nxt = right;
    end else if (cmd.insert && !after) begin
      if (left_after) begin
        nxt.vld = 1'b1;
        nxt.value = cmd.value;
        nxt.prio = cmd.prio;
      end else begin
        nxt = left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.vld <= 1'b0;
    end else begin
      slot.vld <= nxt.vld;
    end
    slot.value <= nxt.value;
    slot.prio <= nxt.prio;
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a chain of CAPACITY cells kept in
// priority order, the entry count and the registered result stage.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_cell.
//
//   Channel | Dir | Fields
//   req     | in  | operation, value, priority_req
//   rsp     | out | front_valid, front_value, front_priority, occupancy, status
//
// All cells compare against the new priority in parallel and shift in the same
// cycle, so one request is taken per cycle unless the result stage stalls.
// The result appears in the output register in the cycle after the request is taken.
// A request is taken while the output register is empty or being read.
// Synchronous reset empties the queue at once.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input logic clk,
  input logic rst,
  spq_req_if.sink req,
  spq_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  cmd_t cmd;
  entry_t cur [CAPACITY];
  entry_t nxt [CAPACITY];
  logic after [CAPACITY];
  logic [CAPACITY-1:0] vld_vec;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW+OCC_W-1:0] count_wide;
  logic go;
  logic full;
  logic empty;
  logic [1:0] status_next;

  localparam entry_t EMPTY_ENTRY = '0;

  assign full = cur[CAPACITY-1].vld;
  assign empty = !cur[0].vld;
  assign go = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;

  assign cmd.insert = go && (req.operation == OP_INSERT) && !full;
  assign cmd.remove = go && (req.operation == OP_REMOVE) && !empty;
  assign cmd.value = req.value;
  assign cmd.prio = req.priority_req;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t l_ent;
    entry_t r_ent;
    logic l_after;
    if (i == 0) begin : g_first
      assign l_ent = EMPTY_ENTRY;
      assign l_after = 1'b1;
    end else begin : g_mid
      assign l_ent = cur[i-1];
      assign l_after = after[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_ent = EMPTY_ENTRY;
    end else begin : g_inner
      assign r_ent = cur[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left       (l_ent),
      .left_after (l_after),
      .right      (r_ent),
      .cur        (cur[i]),
      .after      (after[i]),
      .nxt        (nxt[i])
    );
    assign vld_vec[i] = cur[i].vld;
  end

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + 1'b1;
    end else if (cmd.remove) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    status_next = ST_DONE;
    if (req.operation == OP_INSERT && full) begin
      status_next = ST_FULL;
    end else if (req.operation == OP_REMOVE && empty) begin
      status_next = ST_EMPTY;
    end
  end

  assign count_wide = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (go) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.front_valid <= nxt[0].vld;
      rsp.front_value <= nxt[0].vld ? nxt[0].value : '0;
      rsp.front_priority <= nxt[0].vld ? nxt[0].prio : '0;
      rsp.occupancy <= count_wide[OCC_W-1:0];
      rsp.status <= status_next;
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(vld_vec) == int'(count))
    else $error("entry count disagrees with occupied cells");

  a_front_matches: assert property (@(posedge clk) disable iff (rst)
    (count != '0) == cur[0].vld)
    else $error("front cell occupancy disagrees with count");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (go && req.operation == OP_INSERT && full) |=> (rsp.status == ST_FULL && $stable(count)))
    else $error("insert on full queue not dropped");

  for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      cur[j+1].vld |-> (cur[j].vld && cur[j].prio >= cur[j+1].prio))
      else $error("chain out of priority order");
  end

endmodule
